// ===== hdl/lidar_point_projection_top_defines.svh =====
// Assertion macros shared by the lidar point projection modules.
// Each macro expects signals named clk and rst_n in the using module.
`ifndef LIDAR_POINT_PROJECTION_TOP_DEFINES_SVH
`define LIDAR_POINT_PROJECTION_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LPP_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lidar point projection: assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define LPP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lidar point projection: assertion failed");

`endif

// ===== hdl/lpp_pkg.sv =====
// Shared types, constants and helpers for the lidar point projection block.
// No dependencies; used by the controller, the datapath and the top level.
package lpp_pkg;

    localparam int COORD_WIDTH_DEF = 24;
    localparam int COEF_WIDTH_DEF  = 32;

    localparam int FIELD_W    = 24;
    localparam int REFLECT_W  = 16;
    localparam int CFG_DATA_W = 64;
    localparam int CFG_IDX_W  = 4;
    localparam int COUNT_W    = 16;
    localparam int DROP_BITS  = 12;
    localparam int DIV_STEPS  = 24;
    localparam int MAC_STEPS  = 9;
    localparam int STEP_CNT_W = 5;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_ROW0_A    = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW0_B    = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW1_A    = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW1_B    = 4'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW2_A    = 4'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW2_B    = 4'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_FWD   = 4'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_RETENTION = 4'd7;

    localparam logic [FIELD_W-1:0] MIN_FWD_RESET = 24'd327680;
    localparam logic [FIELD_W-1:0] OUT_MAX       = 24'h7FFFFF;
    localparam logic [FIELD_W-1:0] OUT_MIN       = 24'h800000;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       load;
        logic       mul;
        logic [3:0] mac_idx;
        logic       div_init;
        logic       div_sel;
        logic       div_step;
        logic       div_store;
        logic       out_load;
    } lpp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic pass;
        logic out_free;
    } lpp_status_t;

    // Matrix row of one multiply step (steps run row by row, three columns each).
    function automatic logic [1:0] mac_row(input logic [3:0] idx);
        logic [1:0] r;
        case (idx)
            4'd0, 4'd1, 4'd2: r = 2'd0;
            4'd3, 4'd4, 4'd5: r = 2'd1;
            default:          r = 2'd2;
        endcase
        return r;
    endfunction

    // Matrix column of one multiply step.
    function automatic logic [1:0] mac_col(input logic [3:0] idx);
        logic [1:0] c;
        case (idx)
            4'd0, 4'd3, 4'd6: c = 2'd0;
            4'd1, 4'd4, 4'd7: c = 2'd1;
            default:          c = 2'd2;
        endcase
        return c;
    endfunction

endpackage

// ===== hdl/lpp_ctrl.sv =====
// Sequencer of the lidar point projection block.
// Depends on lpp_pkg and lidar_point_projection_top_defines.svh.
`include "lidar_point_projection_top_defines.svh"

module lpp_ctrl
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  lpp_pkg::lpp_status_t status,
    output lpp_pkg::lpp_cmd_t    cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_MAC   = 3'd1;
    localparam logic [2:0] S_DINIT = 3'd2;
    localparam logic [2:0] S_DIV   = 3'd3;
    localparam logic [2:0] S_DEND  = 3'd4;
    localparam logic [2:0] S_WRITE = 3'd5;

    localparam logic [lpp_pkg::STEP_CNT_W-1:0] MAC_LAST =
        lpp_pkg::STEP_CNT_W'(lpp_pkg::MAC_STEPS);
    localparam logic [lpp_pkg::STEP_CNT_W-1:0] DIV_LAST =
        lpp_pkg::STEP_CNT_W'(lpp_pkg::DIV_STEPS - 1);

    logic [2:0]                      state_reg, state_next;
    logic [lpp_pkg::STEP_CNT_W-1:0]  cnt_reg, cnt_next;
    logic                            sel_reg, sel_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            sel_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            sel_reg   <= sel_next;
        end
    end

    // Next state and commands.
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        sel_next   = sel_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
                if (in_valid && status.pass)
                begin
                    state_next = S_MAC;
                    cnt_next   = '0;
                end
            end
            S_MAC:
            begin
                // Products issue while the count is below MAC_LAST; the last count only adds the final one.
                cmd.mul     = (cnt_reg != MAC_LAST);
                cmd.mac_idx = cnt_reg[3:0];
                cnt_next    = cnt_reg + 1'b1;
                if (cnt_reg == MAC_LAST)
                begin
                    state_next = S_DINIT;
                    sel_next   = 1'b0;
                end
            end
            S_DINIT:
            begin
                cmd.div_init = 1'b1;
                cmd.div_sel  = sel_reg;
                cnt_next     = '0;
                state_next   = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == DIV_LAST)
                begin
                    state_next = S_DEND;
                end
            end
            S_DEND:
            begin
                cmd.div_store = 1'b1;
                cmd.div_sel   = sel_reg;
                if (!sel_reg)
                begin
                    sel_next   = 1'b1;
                    state_next = S_DINIT;
                end
                else
                begin
                    state_next = S_WRITE;
                end
            end
            S_WRITE:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    `LPP_ASSERT_SAME(a_div_count, state_reg == S_DIV, cnt_reg <= DIV_LAST)
    `LPP_ASSERT_NEXT(a_write_done, (state_reg == S_WRITE) && status.out_free,
        state_reg == S_IDLE)
    `LPP_ASSERT_SAME(a_out_slot, cmd.out_load, status.out_free)

endmodule

// ===== hdl/lpp_datapath.sv =====
// Datapath: configuration registers, frame decimation, shared multiplier,
// shared restoring divider and the output word register. Depends on lpp_pkg.
`include "lidar_point_projection_top_defines.svh"

module lpp_datapath
#(
    parameter int COORD_WIDTH = lpp_pkg::COORD_WIDTH_DEF,
    parameter int COEF_WIDTH  = lpp_pkg::COEF_WIDTH_DEF
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [lpp_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [lpp_pkg::CFG_DATA_W-1:0]        cfg_data,
    input  logic [lpp_pkg::FIELD_W-1:0]           point_x,
    input  logic [lpp_pkg::FIELD_W-1:0]           point_y,
    input  logic [lpp_pkg::FIELD_W-1:0]           point_z,
    input  logic [lpp_pkg::REFLECT_W-1:0]         point_reflect,
    input  logic                                  frame_start,
    input  lpp_pkg::lpp_cmd_t                     cmd,
    output lpp_pkg::lpp_status_t                  status,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic [lpp_pkg::FIELD_W-1:0]           pixel_u,
    output logic [lpp_pkg::FIELD_W-1:0]           pixel_v,
    output logic [lpp_pkg::REFLECT_W-1:0]         out_reflect,
    output logic                                  zero_depth
);

    localparam int PROD_W = COORD_WIDTH + COEF_WIDTH;
    localparam int TERM_W = PROD_W - lpp_pkg::DROP_BITS;
    localparam int ACC_W  = TERM_W + 2;
    localparam int NUM_W  = ACC_W + 8;
    localparam int DSH_W  = ACC_W + lpp_pkg::DIV_STEPS - 1;
    localparam int OVF_W  = ACC_W + lpp_pkg::DIV_STEPS;
    localparam int FW     = lpp_pkg::FIELD_W;

    // Configuration registers.
    logic [lpp_pkg::CFG_DATA_W-1:0] coef_reg [6];
    logic [FW-1:0]                  minf_reg;
    logic [lpp_pkg::COUNT_W-1:0]    period_reg;
    logic [lpp_pkg::COUNT_W-1:0]    count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 6; i++)
            begin
                coef_reg[i] <= '0;
            end
            minf_reg   <= lpp_pkg::MIN_FWD_RESET;
            period_reg <= 16'd1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                lpp_pkg::CFG_ROW0_A:    coef_reg[0] <= cfg_data;
                lpp_pkg::CFG_ROW0_B:    coef_reg[1] <= cfg_data;
                lpp_pkg::CFG_ROW1_A:    coef_reg[2] <= cfg_data;
                lpp_pkg::CFG_ROW1_B:    coef_reg[3] <= cfg_data;
                lpp_pkg::CFG_ROW2_A:    coef_reg[4] <= cfg_data;
                lpp_pkg::CFG_ROW2_B:    coef_reg[5] <= cfg_data;
                lpp_pkg::CFG_MIN_FWD:   minf_reg    <= cfg_data[FW-1:0];
                lpp_pkg::CFG_RETENTION: period_reg  <= cfg_data[lpp_pkg::COUNT_W-1:0];
                default:                ;
            endcase
        end
    end

    // Coordinates use their low COORD_WIDTH bits, sign extended.
    function automatic logic signed [COORD_WIDTH-1:0] coord_of(input logic [FW-1:0] v);
        logic [31:0] z;
        z = {{(32 - FW){1'b0}}, v};
        return signed'(z[COORD_WIDTH-1:0]);
    endfunction

    // One coefficient half, low COEF_WIDTH bits sign extended.
    function automatic logic signed [COEF_WIDTH-1:0] coef_half(
        input logic [lpp_pkg::CFG_DATA_W-1:0] r, input logic low);
        logic [31:0] h;
        h = low ? r[31:0] : r[63:32];
        return signed'(h[COEF_WIDTH-1:0]);
    endfunction

    // Frame decimation and the forward gate, evaluated as a word is taken.
    logic [lpp_pkg::COUNT_W-1:0] cnt_eff, period_eff, count_next;
    logic [lpp_pkg::COUNT_W:0]   cnt_inc;
    logic signed [COORD_WIDTH-1:0] x_in, minf_s;

    always_comb
    begin
        cnt_eff    = frame_start ? '0 : count_reg;
        period_eff = (period_reg == '0) ? 16'd1 : period_reg;
        cnt_inc    = {1'b0, cnt_eff} + 17'd1;
        count_next = (cnt_inc >= {1'b0, period_eff}) ? '0 : cnt_inc[lpp_pkg::COUNT_W-1:0];
        x_in       = coord_of(point_x);
        minf_s     = coord_of(minf_reg);
    end

    assign status.pass = (cnt_eff == '0) && (x_in >= minf_s);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (cmd.load)
        begin
            count_reg <= count_next;
        end
    end

    // Point latch.
    logic signed [COORD_WIDTH-1:0] pt_reg [3];
    logic [lpp_pkg::REFLECT_W-1:0] refl_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            pt_reg[0] <= x_in;
            pt_reg[1] <= coord_of(point_y);
            pt_reg[2] <= coord_of(point_z);
            refl_reg  <= point_reflect;
        end
    end

    // Shared multiplier: one coefficient times one coordinate per cycle.
    logic [1:0]                     row_sel, col_sel;
    logic signed [COEF_WIDTH-1:0]   coef_sel;
    logic signed [PROD_W-1:0]       prod_reg;
    logic [1:0]                     prod_row_reg;
    logic                           prod_valid_reg;

    always_comb
    begin
        row_sel  = lpp_pkg::mac_row(cmd.mac_idx);
        col_sel  = lpp_pkg::mac_col(cmd.mac_idx);
        coef_sel = coef_half(coef_reg[{row_sel, col_sel[1]}], col_sel[0]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg <= 1'b0;
        end
        else
        begin
            prod_valid_reg <= cmd.mul;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mul)
        begin
            prod_reg     <= coef_sel * pt_reg[col_sel];
            prod_row_reg <= row_sel;
        end
    end

    // Accumulators start at the constant column (coefficient times 1.0, exact).
    logic signed [ACC_W-1:0] acc_reg [3];
    logic signed [ACC_W-1:0] term;

    function automatic logic signed [ACC_W-1:0] const_term(
        input logic [lpp_pkg::CFG_DATA_W-1:0] r);
        logic signed [COEF_WIDTH-1:0] c;
        c = coef_half(r, 1'b1);
        return ACC_W'(c) <<< 4;
    endfunction

    assign term = ACC_W'(prod_reg >>> lpp_pkg::DROP_BITS);

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            acc_reg[0] <= const_term(coef_reg[1]);
            acc_reg[1] <= const_term(coef_reg[3]);
            acc_reg[2] <= const_term(coef_reg[5]);
        end
        else if (prod_valid_reg)
        begin
            acc_reg[prod_row_reg] <= acc_reg[prod_row_reg] + term;
        end
    end

    // Shared restoring divider, one quotient bit per cycle.
    logic signed [ACC_W-1:0]  num_s, den_s;
    logic [ACC_W-1:0]         num_mag, den_mag;
    logic [NUM_W-1:0]         num_sh;
    logic                     ovf_init, zero_init;
    logic [NUM_W-1:0]         rem_reg;
    logic [DSH_W-1:0]         dsh_reg;
    logic [FW-1:0]            q_reg;
    logic                     ovf_reg, zero_reg, neg_reg, num_neg_reg, num_zero_reg;
    logic [DSH_W-1:0]         rem_ext, rem_diff;
    logic                     rem_ge;

    always_comb
    begin
        num_s     = cmd.div_sel ? acc_reg[1] : acc_reg[0];
        den_s     = acc_reg[2];
        num_mag   = num_s[ACC_W-1] ? ACC_W'(-num_s) : num_s;
        den_mag   = den_s[ACC_W-1] ? ACC_W'(-den_s) : den_s;
        num_sh    = {num_mag, 8'b0};
        zero_init = (den_s == '0);
        ovf_init  = (OVF_W'(num_sh) >= {den_mag, {lpp_pkg::DIV_STEPS{1'b0}}});
        rem_ext   = DSH_W'(rem_reg);
        rem_ge    = (rem_ext >= dsh_reg);
        rem_diff  = rem_ext - dsh_reg;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.div_init)
        begin
            rem_reg      <= (ovf_init || zero_init) ? '0 : num_sh;
            dsh_reg      <= {den_mag, {(lpp_pkg::DIV_STEPS - 1){1'b0}}};
            q_reg        <= '0;
            ovf_reg      <= ovf_init;
            zero_reg     <= zero_init;
            neg_reg      <= num_s[ACC_W-1] ^ den_s[ACC_W-1];
            num_neg_reg  <= num_s[ACC_W-1];
            num_zero_reg <= (num_s == '0);
        end
        else if (cmd.div_step)
        begin
            if (rem_ge)
            begin
                rem_reg <= rem_diff[NUM_W-1:0];
            end
            q_reg   <= {q_reg[FW-2:0], rem_ge};
            dsh_reg <= dsh_reg >> 1;
        end
    end

    // Signed, saturated quotient.
    logic [FW-1:0] div_result;

    always_comb
    begin
        if (zero_reg)
        begin
            if (num_zero_reg)
            begin
                div_result = '0;
            end
            else
            begin
                div_result = num_neg_reg ? lpp_pkg::OUT_MIN : lpp_pkg::OUT_MAX;
            end
        end
        else if (neg_reg)
        begin
            div_result = (ovf_reg || (q_reg > lpp_pkg::OUT_MIN)) ? lpp_pkg::OUT_MIN
                                                                 : (~q_reg + 1'b1);
        end
        else
        begin
            div_result = (ovf_reg || (q_reg > lpp_pkg::OUT_MAX)) ? lpp_pkg::OUT_MAX : q_reg;
        end
    end

    logic [FW-1:0] u_res_reg, v_res_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.div_store)
        begin
            if (cmd.div_sel)
            begin
                v_res_reg <= div_result;
            end
            else
            begin
                u_res_reg <= div_result;
            end
        end
    end

    // Output word register.
    logic out_valid_reg;
    logic [FW-1:0] pixel_u_reg, pixel_v_reg;
    logic [lpp_pkg::REFLECT_W-1:0] out_reflect_reg;
    logic zero_depth_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            pixel_u_reg     <= u_res_reg;
            pixel_v_reg     <= v_res_reg;
            out_reflect_reg <= refl_reg;
            zero_depth_reg  <= zero_reg;
        end
    end

    assign status.out_free = !out_valid_reg || out_ready;
    assign out_valid       = out_valid_reg;
    assign pixel_u         = pixel_u_reg;
    assign pixel_v         = pixel_v_reg;
    assign out_reflect     = out_reflect_reg;
    assign zero_depth      = zero_depth_reg;

    `LPP_ASSERT_SAME(a_rem_bound, cmd.div_step && !zero_reg,
        rem_ext < {dsh_reg, 1'b0})
    `LPP_ASSERT_SAME(a_one_div_cmd, cmd.div_init, !cmd.div_step && !cmd.mul)
    `LPP_ASSERT_NEXT(a_out_loaded, cmd.out_load, out_valid)

endmodule

// ===== hdl/lidar_point_projection_top.sv =====
// Top level of the lidar point projection block.
// Instantiates lpp_ctrl and lpp_datapath; depends on lpp_pkg.
//
// Usage:
//   Input channel in_valid/in_ready carries one lidar point word (x, y, z,
//   reflectivity, frame_start). Output channel out_valid/out_ready carries one
//   pixel word (u, v, reflectivity, zero_depth) for each point that passes the
//   forward gate and the frame decimation; rejected points give no word.
//   Configuration is written through cfg_we, cfg_index and cfg_data while idle.
// Timing:
//   A rejected point is dropped while the block stays idle. A passing point
//   goes from acceptance to its word in the output register through the
//   shared multiplier and accumulators, then two passes through the shared
//   radix-2 divider (one quotient bit per cycle), then one load step.
//   A new point is taken only once the previous passing point is loaded.
// Reset and stalls:
//   Reset clears the matrix, sets the minimum forward distance to 5.0 m and
//   the retention period to one, and empties the output register. A waiting
//   output word does not block the next point; the block holds only when a
//   new result is ready while the previous word is still not taken.
module lidar_point_projection_top
#(
    parameter int COORD_WIDTH = lpp_pkg::COORD_WIDTH_DEF,
    parameter int COEF_WIDTH  = lpp_pkg::COEF_WIDTH_DEF
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [lpp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [lpp_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [lpp_pkg::FIELD_W-1:0]    point_x,
    input  logic [lpp_pkg::FIELD_W-1:0]    point_y,
    input  logic [lpp_pkg::FIELD_W-1:0]    point_z,
    input  logic [lpp_pkg::REFLECT_W-1:0]  point_reflect,
    input  logic                           frame_start,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [lpp_pkg::FIELD_W-1:0]    pixel_u,
    output logic [lpp_pkg::FIELD_W-1:0]    pixel_v,
    output logic [lpp_pkg::REFLECT_W-1:0]  out_reflect,
    output logic                           zero_depth
);

    lpp_pkg::lpp_cmd_t    cmd;
    lpp_pkg::lpp_status_t status;

    // Sequencer.
    lpp_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    // Arithmetic and storage.
    lpp_datapath #(
        .COORD_WIDTH (COORD_WIDTH),
        .COEF_WIDTH  (COEF_WIDTH)
    ) u_datapath
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .point_x       (point_x),
        .point_y       (point_y),
        .point_z       (point_z),
        .point_reflect (point_reflect),
        .frame_start   (frame_start),
        .cmd           (cmd),
        .status        (status),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .pixel_u       (pixel_u),
        .pixel_v       (pixel_v),
        .out_reflect   (out_reflect),
        .zero_depth    (zero_depth)
    );

endmodule
